@@ src/swab_pkg.sv @@
// ---------------------------------------------------------------------------
// swab_pkg: shared types and constants for the seen window ack bitmap
// Window geometry, field widths, stream packing and the ring command struct.
// ---------------------------------------------------------------------------
package swab_pkg;

    // ring geometry
    localparam int WINDOW  = 20;
    localparam int TOKEN_W = 64;
    localparam int PTR_W   = (WINDOW > 1) ? $clog2(WINDOW) : 1;

    // field widths of the stream items
    localparam int SIG_W    = 64;
    localparam int BITMAP_W = 20;
    localparam int COUNT_W  = 16;

    // bitmap bits that map onto ring positions
    localparam int MAP_N = (WINDOW < BITMAP_W) ? WINDOW : BITMAP_W;

    // stream data widths, padded to whole bytes
    localparam int S_TDATA_W = ((SIG_W + 1 + 7) / 8) * 8;
    localparam int M_FIELD_W = BITMAP_W + COUNT_W + SIG_W;
    localparam int M_TDATA_W = ((M_FIELD_W + 7) / 8) * 8;

    typedef logic [PTR_W-1:0]    ptr_t;
    typedef logic [WINDOW-1:0]   win_mask_t;
    typedef logic [TOKEN_W-1:0]  token_t;
    typedef logic [BITMAP_W-1:0] bitmap_t;
    typedef logic [COUNT_W-1:0]  count_t;

    localparam ptr_t   LAST_IDX  = PTR_W'(WINDOW - 1);
    localparam count_t COUNT_MAX = '1;

    // item kinds carried on s_tuser
    localparam logic KIND_ADD  = 1'b0;
    localparam logic KIND_SNAP = 1'b1;

    // commands from the sequencer to the ring storage
    typedef struct packed {
        logic   add_en;
        token_t add_token;
        logic   add_present;
        logic   rd_en;
        ptr_t   rd_addr;
    } ring_cmd_t;

endpackage

@@ src/seen_window_ack_bitmap.sv @@
// ---------------------------------------------------------------------------
// seen_window_ack_bitmap: ring of recent signature tokens with ack bitmap
// Add transfers store a token at the ring tail; snapshot transfers walk the
// ring oldest first and return one result per present token, or one tokenless result if none.
// ---------------------------------------------------------------------------
//
//  channel  | dir | tdata fields (lsb up)                      | tuser     | tlast
//  ---------+-----+--------------------------------------------+-----------+------
//  s_       | in  | sig_token[63:0], sig_nonempty              | kind      | -
//  m_       | out | ack_bitmap, adds_since_snapshot, out_token | has_token | last
//
//  An add is stored while idle; s_tready stays high across back-to-back adds.
//  A snapshot is captured while idle, then the walk steps over each ring
//  position and, at each present token, reads the memory, loads the output
//  register and offers the result.
//  s_tready is low from snapshot capture until its last result transfers.
//  A stalled m_tready holds the current result and the walk.
//  Reset (aresetn low, synchronous) clears the present marks, the tail
//  pointer and the add counter; no clearing pass is needed.
// ---------------------------------------------------------------------------
module seen_window_ack_bitmap (
    input  logic                           aclk,
    input  logic                           aresetn,
    // input stream
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [swab_pkg::S_TDATA_W-1:0] s_tdata,   // sig_token, sig_nonempty
    input  logic                           s_tuser,   // kind
    // result stream
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [swab_pkg::M_TDATA_W-1:0] m_tdata,   // ack_bitmap,
                                                       // adds_since_snapshot,
                                                       // out_token
    output logic                           m_tuser,   // has_token
    output logic                           m_tlast    // last
);
    import swab_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_WALK = 4'b0010,
        ST_LOAD = 4'b0100,
        ST_HOLD = 4'b1000
    } state_t;

    state_t    state_reg,  state_next;
    count_t    cnt_reg,    cnt_next;
    count_t    snap_cnt_reg, snap_cnt_next;
    bitmap_t   bitmap_reg, bitmap_next;
    win_mask_t pend_reg,   pend_next;
    ptr_t      pos_reg,    pos_next;
    ptr_t      phys_reg,   phys_next;
    token_t    tok_reg,    tok_next;
    logic      has_reg,    has_next;
    logic      last_reg,   last_next;

    ring_cmd_t ring_cmd;
    win_mask_t rot_mask;
    ptr_t      wr_ptr;
    token_t    rd_data;

    logic      s_xfer;
    logic      m_xfer;
    win_mask_t rest_mask;
    bitmap_t   snap_bitmap;
    logic [SIG_W-1:0] out_token;

    swab_ring u_ring (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (ring_cmd),
        .rot_mask (rot_mask),
        .wr_ptr   (wr_ptr),
        .rd_data  (rd_data)
    );

    assign s_xfer = s_tvalid && s_tready;
    assign m_xfer = m_tvalid && m_tready;

    // bitmap view of the rotated marks
    always_comb begin
        snap_bitmap = '0;
        for (int i = 0; i < MAP_N; i++) begin
            snap_bitmap[i] = rot_mask[i];
        end
    end

    // marks still pending after the current position
    always_comb begin
        rest_mask = pend_reg;
        rest_mask[pos_reg] = 1'b0;
    end

    // walk sequencer
    always_comb begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        snap_cnt_next = snap_cnt_reg;
        bitmap_next   = bitmap_reg;
        pend_next     = pend_reg;
        pos_next      = pos_reg;
        phys_next     = phys_reg;
        tok_next      = tok_reg;
        has_next      = has_reg;
        last_next     = last_reg;

        ring_cmd             = '0;
        ring_cmd.add_token   = token_t'(s_tdata[SIG_W-1:0]);
        ring_cmd.add_present = s_tdata[SIG_W];
        ring_cmd.rd_addr     = phys_reg;

        case (state_reg)
            ST_IDLE: begin
                if (s_xfer && s_tuser == KIND_ADD) begin
                    ring_cmd.add_en = 1'b1;
                    if (cnt_reg != COUNT_MAX) begin
                        cnt_next = cnt_reg + 1'b1;
                    end
                end else if (s_xfer) begin
                    snap_cnt_next = cnt_reg;
                    cnt_next      = '0;
                    bitmap_next   = snap_bitmap;
                    pend_next     = rot_mask;
                    pos_next      = '0;
                    phys_next     = wr_ptr;
                    if (rot_mask == '0) begin
                        // empty snapshot: a single tokenless result
                        tok_next   = '0;
                        has_next   = 1'b0;
                        last_next  = 1'b1;
                        state_next = ST_HOLD;
                    end else begin
                        state_next = ST_WALK;
                    end
                end
            end
            ST_WALK: begin
                if (pend_reg[pos_reg]) begin
                    ring_cmd.rd_en = 1'b1;
                    state_next     = ST_LOAD;
                end else begin
                    pos_next  = pos_reg + 1'b1;
                    phys_next = (phys_reg == LAST_IDX) ? '0 : phys_reg + 1'b1;
                end
            end
            ST_LOAD: begin
                tok_next   = rd_data;
                has_next   = 1'b1;
                last_next  = (rest_mask == '0);
                state_next = ST_HOLD;
            end
            ST_HOLD: begin
                if (m_tready) begin
                    if (last_reg) begin
                        state_next = ST_IDLE;
                    end else begin
                        pend_next  = rest_mask;
                        pos_next   = pos_reg + 1'b1;
                        phys_next  = (phys_reg == LAST_IDX) ? '0 : phys_reg + 1'b1;
                        state_next = ST_WALK;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // walk and result payload registers
    always_ff @(posedge aclk) begin
        snap_cnt_reg <= snap_cnt_next;
        bitmap_reg   <= bitmap_next;
        pend_reg     <= pend_next;
        pos_reg      <= pos_next;
        phys_reg     <= phys_next;
        tok_reg      <= tok_next;
        has_reg      <= has_next;
        last_reg     <= last_next;
    end

    // result stream packing
    always_comb begin
        out_token = '0;
        out_token[TOKEN_W-1:0] = tok_reg;
        m_tdata = '0;
        m_tdata[M_FIELD_W-1:0] = {out_token, snap_cnt_reg, bitmap_reg};
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = (state_reg == ST_HOLD);
    assign m_tuser  = has_reg;
    assign m_tlast  = last_reg;

`ifndef NO_ASSERTIONS
    // input side is closed while a result is offered
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("input accepted while a result is pending");

    // a tokenless result is the only result of an empty snapshot
    a_empty_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser) |-> (m_tlast && bitmap_reg == '0))
        else $error("tokenless result is not a lone empty snapshot");

    // a snapshot clears the add counter
    a_cnt_cleared: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_xfer && s_tuser == KIND_SNAP) |=> (cnt_reg == '0))
        else $error("add counter not cleared by snapshot");

    // pointers stay inside the window
    a_ptr_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (wr_ptr <= LAST_IDX) && (state_reg == ST_IDLE || pos_reg <= LAST_IDX))
        else $error("ring pointer out of window");

    // a token result comes from a present ring position
    a_token_present: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> pend_reg[pos_reg])
        else $error("token result at a position with no present mark");
`endif

endmodule

@@ src/swab_ring.sv @@
// ---------------------------------------------------------------------------
// swab_ring: token ring storage with present marks
// Holds the token memory, the present marks and the write pointer, and
// presents the marks rotated so that bit 0 is the oldest entry.
// ---------------------------------------------------------------------------
module swab_ring (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  swab_pkg::ring_cmd_t   cmd,
    output swab_pkg::win_mask_t   rot_mask,
    output swab_pkg::ptr_t        wr_ptr,
    output swab_pkg::token_t      rd_data
);
    import swab_pkg::*;

    token_t    token_mem [WINDOW];
    token_t    rd_data_reg;
    win_mask_t present_reg;
    win_mask_t present_next;
    ptr_t      wr_ptr_reg;
    ptr_t      wr_ptr_next;

    // token memory: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (cmd.add_en) begin
            token_mem[wr_ptr_reg] <= cmd.add_token;
        end
        if (cmd.rd_en) begin
            rd_data_reg <= token_mem[cmd.rd_addr];
        end
    end

    // present marks and write pointer update on an add
    always_comb begin
        present_next = present_reg;
        wr_ptr_next  = wr_ptr_reg;
        if (cmd.add_en) begin
            present_next[wr_ptr_reg] = cmd.add_present;
            wr_ptr_next = (wr_ptr_reg == LAST_IDX) ? '0 : wr_ptr_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            present_reg <= '0;
            wr_ptr_reg  <= '0;
        end else begin
            present_reg <= present_next;
            wr_ptr_reg  <= wr_ptr_next;
        end
    end

    // rotate marks so position i is i entries after the write pointer
    always_comb begin
        logic [PTR_W:0] sum;
        rot_mask = '0;
        for (int i = 0; i < WINDOW; i++) begin
            sum = {1'b0, wr_ptr_reg} + (PTR_W+1)'(i);
            if (sum >= (PTR_W+1)'(WINDOW)) begin
                sum = sum - (PTR_W+1)'(WINDOW);
            end
            rot_mask[i] = present_reg[sum[PTR_W-1:0]];
        end
    end

    assign wr_ptr  = wr_ptr_reg;
    assign rd_data = rd_data_reg;

endmodule

@@ bench/tb_top.sv @@
// ---------------------------------------------------------------------------
// tb_top: self-checking bench for the seen window ack bitmap
// Streams add and snapshot transfers into the block with bursty input timing
// and a patterned output stall, predicts every snapshot result from a local
// copy of the ring and compares each result field by field in arrival order.
// ---------------------------------------------------------------------------
module tb_top;
    import swab_pkg::*;

    localparam int HALF_PERIOD = 5;
    localparam int RESET_CYCLES = 6;
    localparam int CYCLE_LIMIT = 2_000_000;
    localparam int DRAIN_CYCLES = 3 * WINDOW + 16;
    localparam int RANDOM_ITEMS = 320;
    localparam int MIXED_ADDS = 40;
    localparam int MAX_PRINTED = 20;

    typedef struct {
        logic   kind;
        token_t sig;
        logic   nonempty;
    } sig_item_t;

    typedef struct {
        bitmap_t bitmap;
        count_t  count;
        token_t  token;
        logic    has_token;
        logic    last;
    } ack_result_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic s_tuser = 1'b0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic m_tuser;
    logic m_tlast;

    // pending input transfers and expected snapshot results
    sig_item_t   pending_items[$];
    ack_result_t ack_expected[$];

    // local copy of the ring state
    token_t ring_tok[WINDOW];
    logic   ring_mark[WINDOW];
    int     tail_ptr = 0;
    count_t add_cnt = '0;

    int error_count = 0;
    int cycle_count = 0;
    int items_sent = 0;
    int snaps_sent = 0;
    int results_seen = 0;
    int empty_snaps = 0;
    int full_snaps = 0;

    seen_window_ack_bitmap uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #HALF_PERIOD aclk = ~aclk;

    // one line per mismatch, printing capped
    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        if (error_count < MAX_PRINTED) begin
            $display("mismatch at cycle %0d: %s got %h expected %h",
                     cycle_count, what, got, want);
        end
        error_count++;
    endtask

    // append one input transfer to the stimulus queue
    task automatic queue_item(input sig_item_t it);
        pending_items.insert(pending_items.size(), it);
    endtask

    // apply one accepted transfer to the ring copy, queue snapshot results
    task automatic track_window(input sig_item_t it);
        bitmap_t     map;
        int          n_present;
        int          k;
        int          idx;
        ack_result_t r;
        map = '0;
        n_present = 0;
        k = 0;
        if (it.kind == KIND_ADD) begin
            ring_tok[tail_ptr] = it.sig;
            ring_mark[tail_ptr] = it.nonempty;
            tail_ptr = (tail_ptr == WINDOW - 1) ? 0 : tail_ptr + 1;
            if (add_cnt != COUNT_MAX)
                add_cnt = add_cnt + 1'b1;
        end else begin
            // bitmap walk from the tail, oldest first
            for (int i = 0; i < WINDOW; i++) begin
                idx = (tail_ptr + i) % WINDOW;
                if (ring_mark[idx]) begin
                    n_present++;
                    if (i < BITMAP_W)
                        map[i] = 1'b1;
                end
            end
            for (int i = 0; i < WINDOW; i++) begin
                idx = (tail_ptr + i) % WINDOW;
                if (ring_mark[idx]) begin
                    r.bitmap = map;
                    r.count = add_cnt;
                    r.token = ring_tok[idx];
                    r.has_token = 1'b1;
                    r.last = (k == n_present - 1);
                    ack_expected.insert(ack_expected.size(), r);
                    k++;
                end
            end
            if (n_present == 0) begin
                r.bitmap = '0;
                r.count = add_cnt;
                r.token = '0;
                r.has_token = 1'b0;
                r.last = 1'b1;
                ack_expected.insert(ack_expected.size(), r);
                empty_snaps++;
            end
            if (n_present == WINDOW)
                full_snaps++;
            add_cnt = '0;
            snaps_sent++;
        end
    endtask

    function automatic sig_item_t mk_add(input token_t sig, input logic nonempty);
        sig_item_t it;
        it.kind = KIND_ADD;
        it.sig = sig;
        it.nonempty = nonempty;
        return it;
    endfunction

    function automatic sig_item_t mk_snap(input token_t junk, input logic junk_bit);
        sig_item_t it;
        it.kind = KIND_SNAP;
        it.sig = junk;
        it.nonempty = junk_bit;
        return it;
    endfunction

    function automatic token_t rand_token();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            default: return {$urandom(), $urandom()};
        endcase
    endfunction

    // input driver: bursts with random gaps
    int burst_left = 4;
    int gap_left = 0;
    always @(posedge aclk) begin
        sig_item_t it;
        sig_item_t done_item;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata <= '0;
            s_tuser <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                done_item.kind = s_tuser;
                done_item.sig = s_tdata[SIG_W-1:0];
                done_item.nonempty = s_tdata[SIG_W];
                track_window(done_item);
                items_sent++;
            end
            if (!s_tvalid || s_tready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end else if (pending_items.size() > 0) begin
                    it = pending_items.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser <= it.kind;
                    s_tdata <= {{(S_TDATA_W - SIG_W - 1){1'b0}}, it.nonempty, it.sig};
                    burst_left--;
                    if (burst_left <= 0) begin
                        burst_left = $urandom_range(1, 16);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
                    end
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver stall pattern: one of four modes, re-chosen at random
    int stall_mode = 0;
    int stall_phase = 0;
    always @(posedge aclk) begin
        stall_phase++;
        if (stall_phase % 64 == 0)
            stall_mode = $urandom_range(0, 3);
        case (stall_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= ($urandom_range(0, 1) == 1);
            2: m_tready <= (stall_phase % 4 == 0);
            default: m_tready <= ((stall_phase / 8) % 2 == 0);
        endcase
    end

    // result monitor: compare each transfer with the oldest expectation
    always @(posedge aclk) begin
        ack_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            results_seen++;
            if (ack_expected.size() == 0) begin
                report_mismatch("unexpected result, token", m_tdata[BITMAP_W+COUNT_W +: SIG_W],
                                64'd0);
            end else begin
                want = ack_expected.pop_front();
                if (m_tdata[BITMAP_W-1:0] !== want.bitmap)
                    report_mismatch("ack_bitmap", 64'(m_tdata[BITMAP_W-1:0]), 64'(want.bitmap));
                if (m_tdata[BITMAP_W +: COUNT_W] !== want.count)
                    report_mismatch("adds_since_snapshot", 64'(m_tdata[BITMAP_W +: COUNT_W]),
                                    64'(want.count));
                if (m_tdata[BITMAP_W+COUNT_W +: SIG_W] !== want.token)
                    report_mismatch("out_token", m_tdata[BITMAP_W+COUNT_W +: SIG_W], want.token);
                if (m_tuser !== want.has_token)
                    report_mismatch("has_token", 64'(m_tuser), 64'(want.has_token));
                if (m_tlast !== want.last)
                    report_mismatch("last", 64'(m_tlast), 64'(want.last));
            end
        end
    end

    // run watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("tb_top NOT OK");
            $finish;
        end
    end

    // stimulus and end of run
    initial begin
        int rand_count;
        int n_adds;
        int fill_pct;
        for (int i = 0; i < WINDOW; i++) begin
            ring_tok[i] = '0;
            ring_mark[i] = 1'b0;
        end

        // directed: empty ring, extreme tokens, cleared mark, ignored operands
        queue_item(mk_snap('1, 1'b1));
        queue_item(mk_add('1, 1'b1));
        queue_item(mk_add('0, 1'b1));
        queue_item(mk_add(64'hA5A5_5A5A_F00F_0FF0, 1'b0));
        queue_item(mk_snap('0, 1'b0));
        queue_item(mk_snap(64'h0123_4567_89AB_CDEF, 1'b1));
        // directed: wrap the tail and fill every entry
        for (int i = 0; i < WINDOW; i++)
            queue_item(mk_add({$urandom(), $urandom()}, 1'b1));
        queue_item(mk_snap('1, 1'b0));

        // a longer run of mixed adds, then an all-cleared ring after data
        queue_item(mk_snap('0, 1'b0));
        for (int i = 0; i < MIXED_ADDS; i++)
            queue_item(mk_add({$urandom(), $urandom()}, 1'($urandom_range(0, 1))));
        queue_item(mk_snap({$urandom(), $urandom()}, 1'b1));
        for (int i = 0; i < WINDOW; i++)
            queue_item(mk_add({$urandom(), $urandom()}, 1'b0));
        queue_item(mk_snap({$urandom(), $urandom()}, 1'b1));

        // random groups of adds closed by a snapshot, some stray snapshots
        rand_count = 0;
        while (rand_count < RANDOM_ITEMS) begin
            case ($urandom_range(0, 3))
                0: fill_pct = 0;
                1: fill_pct = 30;
                2: fill_pct = 70;
                default: fill_pct = 100;
            endcase
            n_adds = ($urandom_range(0, 5) == 0) ? $urandom_range(WINDOW, WINDOW + 10)
                                                 : $urandom_range(0, 12);
            for (int i = 0; i < n_adds; i++)
                queue_item(mk_add(rand_token(), $urandom_range(1, 100) <= fill_pct));
            queue_item(mk_snap(rand_token(), 1'($urandom_range(0, 1))));
            rand_count += n_adds + 1;
            if ($urandom_range(0, 5) == 0) begin
                queue_item(mk_snap(rand_token(), 1'($urandom_range(0, 1))));
                rand_count++;
            end
        end

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        while (pending_items.size() > 0 || s_tvalid || ack_expected.size() > 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("sent %0d transfers with %0d snapshots, checked %0d results",
                 items_sent, snaps_sent, results_seen);
        $display("empty snapshots %0d, full-window snapshots %0d",
                 empty_snaps, full_snaps);
        if (error_count == 0 && ack_expected.size() == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

endmodule
